[rtl/mtfzr_pkg.sv]
// ----------------------------------------------------------------------------
// mtfzr_pkg: shared types and constants of the move-to-front run coder
// Controller states, command and status structs, and symbol codes.
// ----------------------------------------------------------------------------
package mtfzr_pkg;

	localparam int unsigned SYM_W = 9;
	localparam logic [SYM_W-1:0] SYM_RUNA = 9'd0;
	localparam logic [SYM_W-1:0] SYM_RUNB = 9'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_EMIT,
		ST_TAIL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;       // Search the list and latch the byte.
		logic run_step;   // Emit one run digit and shrink the run.
		logic emit_pos;   // Emit the position symbol and update the list.
		logic list_reset; // Return the list to identity order.
		logic last;       // Mark the word as last of its item.
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic front_hit;   // Latched byte was found at the front.
		logic run_nonzero; // Pending run is not zero.
		logic run_final;   // Current digit is the last of the run.
		logic eob;         // Latched end-of-block flag.
		logic in_front;    // Incoming byte sits at the front now.
	} stat_t;

endpackage

[rtl/mtfzr_datapath.sv]
// ----------------------------------------------------------------------------
// mtfzr_datapath: list cells, run counter and output register
// Compare-and-shift cells hold the list; a run counter yields digits.
// ----------------------------------------------------------------------------
module mtfzr_datapath
	import mtfzr_pkg::*;
#(
	parameter int unsigned LIST_SIZE = 256,
	parameter int unsigned RUN_BITS = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       byte_in,
	input  logic             eob_in,
	input  cmd_t             cmd,
	output stat_t            stat,
	output logic [SYM_W-1:0] sym
);

	localparam int unsigned POS_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
	localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

	logic [7:0]          list_q [LIST_SIZE];
	logic [LIST_SIZE-1:0] hit;
	logic [POS_W-1:0]    pos;
	logic                found;
	logic [POS_W-1:0]    pos_q;
	logic [7:0]          byte_q;
	logic                eob_q;
	logic                front_q;
	logic [RUN_BITS-1:0] run_q;

	// Compare every cell with the incoming byte.
	always_comb begin
		for (int i = 0; i < LIST_SIZE; i++) begin
			hit[i] = (list_q[i] == byte_in);
		end
	end

	// Priority encode the first match; a miss takes the last place.
	always_comb begin
		pos = POS_W'(LIST_SIZE - 1);
		found = 1'b0;
		for (int i = LIST_SIZE - 1; i >= 0; i--) begin
			if (hit[i]) begin
				pos = POS_W'(i);
				found = 1'b1;
			end
		end
	end

	// Latch the item and its search result.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= byte_in;
			eob_q <= eob_in;
			pos_q <= pos;
			front_q <= found && (pos == '0);
		end
	end

	// List cells: shift below the hit, or restore identity order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIST_SIZE; i++) list_q[i] <= 8'(i);
		end else if (cmd.list_reset) begin
			for (int i = 0; i < LIST_SIZE; i++) list_q[i] <= 8'(i);
		end else if (cmd.emit_pos) begin
			for (int i = 1; i < LIST_SIZE; i++) begin
				if (POS_W'(i) <= pos_q) list_q[i] <= list_q[i-1];
			end
			list_q[0] <= byte_q;
		end
	end

	// Run counter: count front hits, peel bijective digits on flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.take && found && pos == '0) begin
			if (run_q != RUN_MAX) run_q <= run_q + RUN_BITS'(1);
		end else if (cmd.run_step) begin
			if (run_q[0]) run_q <= (run_q - RUN_BITS'(1)) >> 1;
			else run_q <= (run_q - RUN_BITS'(2)) >> 1;
		end
	end

	// Output symbol mux.
	always_comb begin
		if (cmd.run_step) sym = run_q[0] ? SYM_RUNA : SYM_RUNB;
		else sym = SYM_W'(pos_q) + SYM_W'(1);
	end

	assign stat.front_hit = front_q;
	assign stat.run_nonzero = (run_q != '0);
	assign stat.run_final = (run_q == RUN_BITS'(1)) || (run_q == RUN_BITS'(2));
	assign stat.eob = eob_q;
	assign stat.in_front = found && (pos == '0);

endmodule

[rtl/mtfzr_ctrl.sv]
// ----------------------------------------------------------------------------
// mtfzr_ctrl: sequencing of run flushes, position symbols and output handshake
// Drives one output word per step into a holding register.
// ----------------------------------------------------------------------------
module mtfzr_ctrl
	import mtfzr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_eob,
	output logic  in_ready,
	input  stat_t stat,
	input  logic  out_free,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic busy_fire;

	assign busy_fire = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				// Front hit without end of block stays idle.
				if (busy_fire && !(stat.in_front && !in_eob)) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (out_free) begin
					if (!stat.run_nonzero) begin
						// No run: the position symbol went out in this cycle.
						state_d = stat.eob ? ST_TAIL : ST_IDLE;
					end else if (stat.run_final) begin
						state_d = stat.front_hit ? ST_IDLE : ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) state_d = stat.eob ? ST_TAIL : ST_IDLE;
			end
			ST_TAIL: begin
				// Eob after a position symbol: list already reset, run is zero.
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = busy_fire;
			end
			ST_FLUSH: begin
				if (out_free && stat.run_nonzero) begin
					cmd.run_step = 1'b1;
					cmd.last = stat.front_hit && stat.run_final;
					cmd.list_reset = stat.front_hit && stat.run_final && stat.eob;
				end else if (out_free && !stat.front_hit) begin
					cmd.emit_pos = 1'b1;
					cmd.last = 1'b1;
					cmd.list_reset = stat.eob;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit_pos = 1'b1;
					cmd.last = 1'b1;
					cmd.list_reset = stat.eob;
				end
			end
			ST_TAIL: ;
			default: ;
		endcase
	end

endmodule

[rtl/mtf_zero_run_encoder.sv]
// ----------------------------------------------------------------------------
// mtf_zero_run_encoder: move-to-front coder with RUNA/RUNB zero-run coding
//
//  channel | dir | tdata                | tuser / tlast
//  s_axis  | in  | byte_in [7:0]        | tlast = end_of_block
//  m_axis  | out | symbol [8:0] (16 b)  | tlast = last_of_item
//
// A byte at the list front that does not end the block only grows the run;
// one that ends it then enters the flush state and emits one word per run digit.
// Any other byte enters the flush state, emits its run digits and then its
// position symbol, and passes through the tail state when it ends the block.
// Reset puts the list in identity order and clears the run at once.
// A stalled output register holds the controller in place.
// ----------------------------------------------------------------------------
module mtf_zero_run_encoder
	import mtfzr_pkg::*;
#(
	parameter int unsigned LIST_SIZE = 256,
	parameter int unsigned RUN_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
	input  logic        s_axis_tlast,  // end_of_block
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [8:0] symbol, rest zero
	output logic        m_axis_tlast   // last_of_item
);

	cmd_t cmd;
	stat_t stat;
	logic [SYM_W-1:0] sym;
	logic out_free;
	logic in_fire;
	logic valid_q;
	logic [SYM_W-1:0] sym_q;
	logic last_q;

	assign out_free = !valid_q || m_axis_tready;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	mtfzr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_eob   (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.out_free (out_free),
		.cmd      (cmd)
	);

	mtfzr_datapath #(
		.LIST_SIZE (LIST_SIZE),
		.RUN_BITS  (RUN_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (s_axis_tdata),
		.eob_in  (s_axis_tlast),
		.cmd     (cmd),
		.stat    (stat),
		.sym     (sym)
	);

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.run_step || cmd.emit_pos) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_step || cmd.emit_pos) begin
			sym_q <= sym;
			last_q <= cmd.last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {7'd0, sym_q};
	assign m_axis_tlast = last_q;

`ifndef SYNTHESIS
	// A word is only loaded when the register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.run_step || cmd.emit_pos) |-> out_free)
		else $error("output word overwritten");

	// Run digit and position symbol never issue together.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.run_step && cmd.emit_pos))
		else $error("two words in one cycle");

	// No input taken while a word is being produced.
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !(cmd.run_step || cmd.emit_pos))
		else $error("input taken while busy");
`endif

endmodule

[verif/mtfzr_checker.sv]
// ----------------------------------------------------------------------------
// mtfzr_checker: scoreboard for the move-to-front run coder
// Watches both stream channels, predicts the symbol words that each accepted
// input byte causes, and compares every output word with the oldest
// expectation. Counts failures for the testbench top.
// ----------------------------------------------------------------------------
module mtfzr_checker
	import mtfzr_pkg::*;
#(
	parameter int unsigned LIST_SIZE = 256,
	parameter int unsigned RUN_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending_words
);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} sym_word_t;

	localparam logic [RUN_BITS-1:0] RUN_CAP = {RUN_BITS{1'b1}};

	logic [7:0]          order_list [LIST_SIZE];
	logic [RUN_BITS-1:0] front_run;
	sym_word_t           symbol_queue [$];

	// Put the list back in identity order.
	function automatic void reset_order();
		for (int i = 0; i < LIST_SIZE; i++)
			order_list[i] = i[7:0];
	endfunction

	// Emit the bijective base-2 digits of the pending run, low digit first.
	function automatic void flush_run(ref sym_word_t words [$]);
		logic [RUN_BITS-1:0] k;
		k = front_run;
		while (k != 0) begin
			if (k[0]) begin
				words.push_back('{SYM_RUNA, 1'b0});
				k = (k - RUN_BITS'(1)) >> 1;
			end else begin
				words.push_back('{SYM_RUNB, 1'b0});
				k = (k - RUN_BITS'(2)) >> 1;
			end
		end
		front_run = '0;
	endfunction

	// Predict the words that one input byte causes.
	function automatic void code_byte(logic [7:0] b, logic eob);
		sym_word_t words [$];
		int pos;
		pos = LIST_SIZE - 1;
		for (int i = 0; i < LIST_SIZE; i++)
			if (order_list[i] == b) begin
				pos = i;
				break;
			end
		if (pos == 0 && order_list[0] == b) begin
			if (front_run != RUN_CAP)
				front_run++;
		end else begin
			flush_run(words);
			words.push_back('{SYM_W'(pos + 1), 1'b0});
			for (int i = pos; i > 0; i--)
				order_list[i] = order_list[i-1];
			order_list[0] = b;
		end
		if (eob) begin
			flush_run(words);
			reset_order();
		end
		if (words.size() > 0)
			words[words.size()-1].last = 1'b1;
		foreach (words[i])
			symbol_queue.push_back(words[i]);
	endfunction

	initial begin
		fail_count = 0;
		pending_words = 0;
		front_run = '0;
		reset_order();
	end

	// Predict on accepted inputs and compare accepted outputs.
	always @(posedge clk) begin
		sym_word_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				code_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (symbol_queue.size() == 0) begin
					$error("unexpected word: symbol %0d last %0b",
						m_axis_tdata[SYM_W-1:0], m_axis_tlast);
					fail_count++;
				end else begin
					want = symbol_queue.pop_front();
					if (m_axis_tdata[SYM_W-1:0] !== want.symbol) begin
						$error("symbol: expected %0d, actual %0d",
							want.symbol, m_axis_tdata[SYM_W-1:0]);
						fail_count++;
					end
					if (m_axis_tdata[15:SYM_W] !== '0) begin
						$error("tdata pad: expected 0, actual %0h",
							m_axis_tdata[15:SYM_W]);
						fail_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_of_item: expected %0b, actual %0b",
							want.last, m_axis_tlast);
						fail_count++;
					end
				end
			end
			pending_words = symbol_queue.size();
		end
	end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the move-to-front run coder
// Drives directed and random byte streams with runs of front bytes, block
// ends and random gaps on both sides, plus one long output stall. A checker
// module predicts and compares the symbol words.
// ----------------------------------------------------------------------------
module testbench;
	import mtfzr_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending_words;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_output;
	int          quiet_cycles;
	logic [7:0]  last_byte;

	mtf_zero_run_encoder DUT (.*);
	mtfzr_checker checker_i (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: random stalls, or a full hold-off while requested.
	initial m_axis_tready = 1'b0;
	always @(negedge clk)
		m_axis_tready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one byte after an optional gap and wait for its acceptance.
	task automatic send_byte(logic [7:0] b, logic eob);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eob;
		last_byte = b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A random burst: half the picks repeat the last byte sent, the rest are others.
	task automatic send_burst();
		int n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
				1: send_byte(8'($urandom_range(7)), 1'b0);
				default: send_byte(last_byte, $urandom_range(20) == 0);
			endcase
		end
	endtask

	initial begin
		quiet_cycles = 0;
		hold_output = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		last_byte = 8'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: front byte, last entry, block ends, empty and long runs.
		send_byte(8'd0, 1'b0);
		send_byte(8'd0, 1'b1);
		send_byte(8'd255, 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte(8'd1, 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(8'd0, 1'b1);
		send_byte(8'd128, 1'b1);
		for (int i = 0; i < 7; i++)
			send_byte(8'd0, 1'b0);
		send_byte(8'd0, 1'b1);
		send_byte(8'd170, 1'b0);
		send_byte(8'd85, 1'b0);
		send_byte(8'd170, 1'b1);

		// Random phases with changing gap rates.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 85 : 0;
			recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 13 : 0;
			for (int k = 0; k < 6; k++)
				send_burst();
		end

		// Long output hold-off while input keeps coming.
		fork
			begin
				hold_output = 1'b1;
				repeat (200) @(negedge clk);
				hold_output = 1'b0;
			end
			for (int i = 0; i < 20; i++)
				send_byte(8'($urandom_range(255)), 1'b0);
		join

		// A run long enough to need several digits, ended by the block end.
		for (int i = 0; i < 40; i++)
			send_byte(8'd9, 1'b0);
		send_byte(8'd9, 1'b1);
		s_axis_tvalid <= 1'b0;

		while (pending_words != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/mtfzr_pkg.sv
rtl/mtfzr_datapath.sv
rtl/mtfzr_ctrl.sv
rtl/mtf_zero_run_encoder.sv
verif/mtfzr_checker.sv
verif/testbench.sv
